/* hw/rtl/sael_pkg.sv */
// Shared types and constants for the scanline active edge list.
// No dependencies; imported by the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none
package sael_pkg;

  localparam int MAX_ACTIVE = 64;
  localparam int ROW_LIMIT  = 240;
  localparam int POLY_LIMIT = 1024;

  localparam int X_W    = 32;
  localparam int ROW_W  = 8;
  localparam int POLY_W = 10;
  localparam int DROP_W = 16;
  localparam int IDX_W  = $clog2(MAX_ACTIVE);
  localparam int CNT_W  = $clog2(MAX_ACTIVE + 1);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_INSERT = 2'd1,
    OP_ROW = 2'd2,
    OP_NONE = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_CLEARED = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_DROPPED = 2'd2,
    KIND_ENTRY = 2'd3
  } kind_e;

  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] step;
    logic [ROW_W-1:0]      end_row;
    logic [POLY_W-1:0]     poly;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

/* hw/rtl/sael_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sael_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] wa_i,
  input  wire logic [WIDTH-1:0]         wd_i,
  input  wire logic [$clog2(DEPTH)-1:0] ra_i,
  output logic      [WIDTH-1:0]         rd_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
    rd_o <= mem[ra_i];
  end

endmodule
`default_nettype wire

/* hw/rtl/scanline_active_edge_list.sv */
// Top level of the scanline active edge list: sequencer plus edge RAM.
// Depends on sael_pkg and sael_ram.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//   An item is taken when start_i is high and busy_o is low. opcode_i picks
//   start frame, insert edge or row done; opcode 3 is taken and ignored.
//   Results come out one per strobe cycle of result_valid_o; last_o marks the
//   final result of an item. The receiver cannot stall the block.
//   The list lives in one RAM, kept physically sorted by x.
// Timing:
//   Start frame, a dropped insert and a row done on an empty list give their
//   result the cycle after acceptance and never raise busy_o.
//   Insert walks from the end of the list towards position p, one RAM read
//   and compare per step while entries shift up.
//   Row done with n entries: each entry is read and then emitted in turn,
//   stepping and compacting survivors in place; then an insertion sort over
//   the m survivors, one RAM read and compare per step. The single read
//   port of the RAM sets this order of work.
// Reset: list empty, row 0, drop count 0. RAM contents are not cleared;
//   entries beyond the count are never used.
module scanline_active_edge_list (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [1:0]                   opcode_i,
  input  wire logic [sael_pkg::X_W-1:0]     start_x_i,
  input  wire logic [sael_pkg::X_W-1:0]     x_step_i,
  input  wire logic [sael_pkg::ROW_W-1:0]   end_row_i,
  input  wire logic [sael_pkg::POLY_W-1:0]  poly_id_i,
  output logic                              result_valid_o,
  output logic [1:0]                        kind_o,
  output logic                              entry_valid_o,
  output logic [sael_pkg::X_W-1:0]          entry_x_o,
  output logic [sael_pkg::POLY_W-1:0]       entry_poly_o,
  output logic                              last_o,
  output logic [sael_pkg::DROP_W-1:0]       drop_total_o
);
  import sael_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_INS_RD, ST_INS_CHK, ST_ROW_RD, ST_ROW_USE,
    ST_SRT_KEY, ST_SRT_RD, ST_SRT_CMP
  } state_e;

  localparam int LIM_W = ROW_W + 1;

  state_e              state_q;
  logic [CNT_W-1:0]    count_q, k_q, n_q, m_q, i_q, j_q;
  logic [ROW_W-1:0]    row_q;
  logic [LIM_W-1:0]    limit_q;
  logic [DROP_W-1:0]   drops_q;
  entry_t              new_q, key_q;

  logic                res_valid_q, res_evalid_q, res_last_q;
  kind_e               res_kind_q;
  logic [X_W-1:0]      res_x_q;
  logic [POLY_W-1:0]   res_poly_q;
  logic [DROP_W-1:0]   res_drops_q;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_wa, ram_ra;
  entry_t              ram_wd, ram_rd;
  logic [ENTRY_W-1:0]  ram_rd_bits;

  logic                accept, bad_insert, alive;
  logic [X_W:0]        sum;
  logic [X_W-1:0]      stepped;
  logic [ROW_W-1:0]    end_clamped;
  logic [DROP_W-1:0]   drops_inc;

  assign accept    = start_i && !busy_o;
  assign ram_rd    = entry_t'(ram_rd_bits);
  assign drops_inc = (drops_q == '1) ? drops_q : drops_q + DROP_W'(1);

  assign bad_insert  = (count_q >= CNT_W'(MAX_ACTIVE))
                    || ({1'b0, poly_id_i} >= (POLY_W+1)'(POLY_LIMIT));
  assign end_clamped = (end_row_i > ROW_W'(ROW_LIMIT)) ? ROW_W'(ROW_LIMIT) : end_row_i;

  // Saturating step of the entry just read.
  assign sum   = {ram_rd.x[X_W-1], ram_rd.x} + {ram_rd.step[X_W-1], ram_rd.step};
  always_comb begin
    if (sum[X_W] != sum[X_W-1]) begin
      stepped = sum[X_W] ? {1'b1, {(X_W-1){1'b0}}} : {1'b0, {(X_W-1){1'b1}}};
    end else begin
      stepped = sum[X_W-1:0];
    end
  end
  assign alive = {1'b0, ram_rd.end_row} > limit_q;

  // RAM port control.
  always_comb begin
    ram_we = 1'b0;
    ram_wa = '0;
    ram_ra = '0;
    ram_wd = new_q;
    case (state_q)
      ST_INS_RD: begin
        ram_ra = IDX_W'(k_q - CNT_W'(1));
        if (k_q == '0) begin
          ram_we = 1'b1;
        end
      end
      ST_INS_CHK: begin
        ram_we = 1'b1;
        ram_wa = k_q[IDX_W-1:0];
        ram_wd = ($signed(ram_rd.x) >= $signed(new_q.x)) ? ram_rd : new_q;
      end
      ST_ROW_RD: ram_ra = k_q[IDX_W-1:0];
      ST_ROW_USE: begin
        ram_we = alive;
        ram_wa = m_q[IDX_W-1:0];
        ram_wd = '{x: stepped, step: ram_rd.step, end_row: ram_rd.end_row,
                   poly: ram_rd.poly};
      end
      ST_SRT_KEY: ram_ra = i_q[IDX_W-1:0];
      ST_SRT_RD: begin
        ram_ra = IDX_W'(j_q - CNT_W'(1));
        ram_wd = key_q;
        if (j_q == '0) begin
          ram_we = 1'b1;
        end
      end
      ST_SRT_CMP: begin
        ram_we = 1'b1;
        ram_wa = j_q[IDX_W-1:0];
        ram_wd = ($signed(ram_rd.x) > $signed(key_q.x)) ? ram_rd : key_q;
      end
      default: ;
    endcase
  end

  sael_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ACTIVE)) u_ram (
    .clk_i (clk_i),
    .we_i  (ram_we),
    .wa_i  (ram_wa),
    .wd_i  (ram_wd),
    .ra_i  (ram_ra),
    .rd_o  (ram_rd_bits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      row_q        <= '0;
      drops_q      <= '0;
      k_q          <= '0;
      n_q          <= '0;
      m_q          <= '0;
      i_q          <= '0;
      j_q          <= '0;
      limit_q      <= '0;
      new_q        <= '0;
      key_q        <= '0;
      res_valid_q  <= 1'b0;
      res_evalid_q <= 1'b0;
      res_last_q   <= 1'b0;
      res_kind_q   <= KIND_CLEARED;
      res_x_q      <= '0;
      res_poly_q   <= '0;
      res_drops_q  <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            res_evalid_q <= 1'b0;
            res_x_q      <= '0;
            res_poly_q   <= '0;
            res_last_q   <= 1'b1;
            case (opcode_e'(opcode_i))
              OP_START: begin
                count_q     <= '0;
                row_q       <= '0;
                drops_q     <= '0;
                res_valid_q <= 1'b1;
                res_kind_q  <= KIND_CLEARED;
                res_drops_q <= '0;
              end
              OP_INSERT: begin
                if (bad_insert) begin
                  drops_q     <= drops_inc;
                  res_valid_q <= 1'b1;
                  res_kind_q  <= KIND_DROPPED;
                  res_drops_q <= drops_inc;
                end else begin
                  new_q   <= '{x: start_x_i, step: x_step_i, end_row: end_clamped,
                               poly: poly_id_i};
                  k_q     <= count_q;
                  state_q <= ST_INS_RD;
                end
              end
              OP_ROW: begin
                limit_q <= {1'b0, row_q} + LIM_W'(1);
                if (row_q < ROW_W'(ROW_LIMIT)) begin
                  row_q <= row_q + ROW_W'(1);
                end
                if (count_q == '0) begin
                  res_valid_q <= 1'b1;
                  res_kind_q  <= KIND_ENTRY;
                  res_drops_q <= drops_q;
                end else begin
                  n_q     <= count_q;
                  k_q     <= '0;
                  m_q     <= '0;
                  state_q <= ST_ROW_RD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_INS_RD: begin
          if (k_q == '0) begin
            count_q     <= count_q + CNT_W'(1);
            res_valid_q <= 1'b1;
            res_kind_q  <= KIND_ACCEPTED;
            res_drops_q <= drops_q;
            state_q     <= ST_IDLE;
          end else begin
            state_q <= ST_INS_CHK;
          end
        end
        ST_INS_CHK: begin
          if ($signed(ram_rd.x) >= $signed(new_q.x)) begin
            k_q     <= k_q - CNT_W'(1);
            state_q <= ST_INS_RD;
          end else begin
            count_q     <= count_q + CNT_W'(1);
            res_valid_q <= 1'b1;
            res_kind_q  <= KIND_ACCEPTED;
            res_drops_q <= drops_q;
            state_q     <= ST_IDLE;
          end
        end
        ST_ROW_RD: state_q <= ST_ROW_USE;
        ST_ROW_USE: begin
          res_valid_q  <= 1'b1;
          res_kind_q   <= KIND_ENTRY;
          res_evalid_q <= 1'b1;
          res_x_q      <= ram_rd.x;
          res_poly_q   <= ram_rd.poly;
          res_last_q   <= (k_q + CNT_W'(1)) == n_q;
          res_drops_q  <= drops_q;
          k_q          <= k_q + CNT_W'(1);
          if ((k_q + CNT_W'(1)) == n_q) begin
            // survivors are stepped and compacted; sort them next if more than one survived
            count_q <= alive ? m_q + CNT_W'(1) : m_q;
            i_q     <= CNT_W'(1);
            state_q <= ((alive ? m_q + CNT_W'(1) : m_q) > CNT_W'(1)) ? ST_SRT_KEY
                                                                     : ST_IDLE;
          end else begin
            state_q <= ST_ROW_RD;
          end
          if (alive) begin
            m_q <= m_q + CNT_W'(1);
          end
        end
        ST_SRT_KEY: begin
          j_q     <= i_q;
          state_q <= ST_SRT_RD;
        end
        ST_SRT_RD: begin
          if (state_q == ST_SRT_RD && j_q == i_q) begin
            key_q <= ram_rd;
          end
          if (j_q == '0) begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= ((i_q + CNT_W'(1)) == count_q) ? ST_IDLE : ST_SRT_KEY;
          end else begin
            state_q <= ST_SRT_CMP;
          end
        end
        ST_SRT_CMP: begin
          if ($signed(ram_rd.x) > $signed(key_q.x)) begin
            j_q     <= j_q - CNT_W'(1);
            state_q <= ST_SRT_RD;
          end else begin
            i_q     <= i_q + CNT_W'(1);
            state_q <= ((i_q + CNT_W'(1)) == count_q) ? ST_IDLE : ST_SRT_KEY;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign kind_o         = res_kind_q;
  assign entry_valid_o  = res_evalid_q;
  assign entry_x_o      = res_x_q;
  assign entry_poly_o   = res_poly_q;
  assign last_o         = res_last_q;
  assign drop_total_o   = res_drops_q;

endmodule
`default_nettype wire

/* hw/rtl/sael_chk.sv */
// Port-level checker for the scanline active edge list, with its bind.
// Depends on sael_pkg and scanline_active_edge_list.
`timescale 1ns / 1ps
`default_nettype none
module sael_chk (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start_i,
  input wire logic                         busy_o,
  input wire logic [1:0]                   opcode_i,
  input wire logic                         result_valid_o,
  input wire logic [1:0]                   kind_o,
  input wire logic                         entry_valid_o,
  input wire logic [sael_pkg::X_W-1:0]     entry_x_o,
  input wire logic                         last_o,
  input wire logic [sael_pkg::DROP_W-1:0]  drop_total_o
);
  import sael_pkg::*;

  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == KIND_CLEARED |-> last_o && drop_total_o == '0)
    else $error("frame clear result malformed");

  a_single_kinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o != KIND_ENTRY |-> last_o && !entry_valid_o)
    else $error("non-entry result not single");

  a_empty_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == KIND_ENTRY && !entry_valid_o |-> last_o && entry_x_o == '0)
    else $error("empty row marker malformed");

  a_row_reacts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && opcode_i == OP_ROW |=> result_valid_o || busy_o)
    else $error("row done ignored");

endmodule

bind scanline_active_edge_list sael_chk u_sael_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .opcode_i       (opcode_i),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .entry_valid_o  (entry_valid_o),
  .entry_x_o      (entry_x_o),
  .last_o         (last_o),
  .drop_total_o   (drop_total_o)
);
`default_nettype wire
